// ===== rtl/core/hwd_pkg.sv =====
`default_nettype none
package hwd_pkg;

  localparam int IDX_W         = 10;
  localparam int BYTE_W        = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
  localparam int RUN_LEN       = 4;
  localparam int REP_W         = $clog2(RUN_LEN + 1);
  localparam int NODE_W        = 2 * IDX_W + 1;

  localparam logic [IDX_W-1:0] SYM_RUN = IDX_W'(256);
  localparam logic [IDX_W-1:0] SYM_END = IDX_W'(257);

  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_PRIO = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] left;
  } node_t;

  typedef struct packed {
    logic              vld;
    logic              flush;
    logic [BYTE_W-1:0] data;
    logic              eod;
  } emit_req_t;

  typedef struct packed {
    logic take;
    logic done;
  } emit_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/hwd_ram.sv =====
`default_nettype none
module hwd_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 515
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/hwd_out.sv =====
`default_nettype none
module hwd_out
  import hwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire emit_req_t         req,
  output emit_sts_t              sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_end_of_data,
  output logic                   out_last
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_eod_r, out_eod_nxt;
  logic              out_last_r, out_last_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [BYTE_W-1:0] pend_data_r, pend_data_nxt;
  logic              pend_eod_r, pend_eod_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign sts.take  = !pend_vld_r || slot_free;
  assign sts.done  = !pend_vld_r || slot_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_eod_nxt   = out_eod_r;
    out_last_nxt  = out_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_data_nxt = pend_data_r;
    pend_eod_nxt  = pend_eod_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // hold one item back so the final one can carry last
    if (req.vld && sts.take) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_data_r;
        out_eod_nxt   = pend_eod_r;
        out_last_nxt  = 1'b0;
      end
      pend_vld_nxt  = 1'b1;
      pend_data_nxt = req.data;
      pend_eod_nxt  = req.eod;
    end else if (req.flush && pend_vld_r && slot_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend_data_r;
      out_eod_nxt   = pend_eod_r;
      out_last_nxt  = 1'b1;
      pend_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
    out_byte_r  <= out_byte_nxt;
    out_eod_r   <= out_eod_nxt;
    out_last_r  <= out_last_nxt;
    pend_data_r <= pend_data_nxt;
    pend_eod_r  <= pend_eod_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_end_of_data = out_eod_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/huffman_tree_walk_decoder.sv =====
`default_nettype none
// Huffman tree-walk decoder. Node items (in_cmd 0) each write one entry of the node
// table. Byte items (in_cmd 1) are decoded one code bit at a time, least significant
// bit first: each bit passes ST_CUR, ST_NXT and ST_CHK for the two dependent reads
// of the node table (current node, then the child) through its one registered read
// port. Each result item is offered from ST_EMIT, which waits while the result side
// stalls; a byte that hits the end marker stops early. Results leave through an
// output register with one item held back so the last one of a byte can be flagged.
// in_ready is high only between byte items. The node table has no reset and must be
// written before it is walked.
module huffman_tree_walk_decoder
  import hwd_pkg::*;
#(
  parameter int NODE_SLOTS = 515
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [IDX_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  input  wire logic [IDX_W-1:0]  in_node_index,
  input  wire logic [IDX_W-1:0]  in_left_child,
  input  wire logic [IDX_W-1:0]  in_right_child,
  input  wire logic              in_is_leaf,
  input  wire logic [BYTE_W-1:0] in_code_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_end_of_data,
  output logic                   out_last
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam logic [IDX_W-1:0] SLOTS_V = IDX_W'(NODE_SLOTS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CUR  = 3'd1;
  localparam logic [2:0] ST_NXT  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_END  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [BYTE_W-1:0]    shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic [IDX_W-1:0]     walk_r, walk_nxt;
  logic                 at_start_r, at_start_nxt;
  logic [IDX_W-1:0]     root_r;
  logic [BYTE_W-1:0]    prio_r;
  logic [IDX_W-1:0]     next_r, next_nxt;
  logic                 rd_oor_r;
  logic [BYTE_W-1:0]    sym_data_r, sym_data_nxt;
  logic                 sym_eod_r, sym_eod_nxt;
  logic [REP_W-1:0]     rep_r, rep_nxt;

  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_oor;
  logic [NODE_W-1:0]    ram_q;
  node_t                ent;
  logic                 wr_en;
  logic                 in_acc;
  logic                 last_bit;
  emit_req_t            req;
  emit_sts_t            sts;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && !in_cmd && (in_node_index < SLOTS_V);
  assign rd_oor   = !(rd_addr < SLOTS_V);
  assign ent      = rd_oor_r ? node_t'('0) : node_t'(ram_q);
  assign last_bit = (bit_r == BIT_CNT_W'(BITS_PER_BYTE - 1));

  hwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_node_index[AW-1:0]),
    .wdata ({in_is_leaf, in_right_child, in_left_child}),
    .raddr (rd_oor ? {AW{1'b0}} : rd_addr[AW-1:0]),
    .rdata (ram_q)
  );

  hwd_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_end_of_data (out_end_of_data),
    .out_last        (out_last)
  );

  always_comb begin
    state_nxt    = state_r;
    shift_nxt    = shift_r;
    bit_nxt      = bit_r;
    walk_nxt     = walk_r;
    at_start_nxt = at_start_r;
    next_nxt     = next_r;
    sym_data_nxt = sym_data_r;
    sym_eod_nxt  = sym_eod_r;
    rep_nxt      = rep_r;
    rd_addr      = at_start_r ? root_r : walk_r;
    req          = '0;
    req.data     = sym_data_r;
    req.eod      = sym_eod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_cmd) begin
          shift_nxt = in_code_byte;
          bit_nxt   = '0;
          state_nxt = ST_CUR;
        end
      end
      ST_CUR: begin
        state_nxt = ST_NXT;
      end
      ST_NXT: begin
        rd_addr   = shift_r[0] ? ent.right : ent.left;
        next_nxt  = rd_addr;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (ent.leaf) begin
          walk_nxt     = '0;
          at_start_nxt = 1'b1;
          sym_eod_nxt  = (next_r == SYM_END);
          rep_nxt      = REP_W'(1);
          if (next_r == SYM_RUN) begin
            sym_data_nxt = prio_r;
            rep_nxt      = REP_W'(RUN_LEN);
          end else if (next_r < SYM_RUN) begin
            sym_data_nxt = next_r[BYTE_W-1:0];
          end else begin
            sym_data_nxt = '0;
          end
          state_nxt = ST_EMIT;
        end else begin
          walk_nxt     = next_r;
          at_start_nxt = 1'b0;
          shift_nxt    = shift_r >> 1;
          bit_nxt      = bit_r + BIT_CNT_W'(1);
          state_nxt    = last_bit ? ST_END : ST_CUR;
        end
      end
      ST_EMIT: begin
        req.vld = 1'b1;
        if (sts.take) begin
          rep_nxt = rep_r - REP_W'(1);
          if (rep_r == REP_W'(1)) begin
            if (sym_eod_r) begin
              state_nxt = ST_END;
            end else begin
              shift_nxt = shift_r >> 1;
              bit_nxt   = bit_r + BIT_CNT_W'(1);
              state_nxt = last_bit ? ST_END : ST_CUR;
            end
          end
        end
      end
      ST_END: begin
        req.flush = 1'b1;
        if (sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      walk_r     <= '0;
      at_start_r <= 1'b1;
      root_r     <= IDX_W'(514);
      prio_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      walk_r     <= walk_nxt;
      at_start_r <= at_start_nxt;
      if (cfg_we && cfg_index == REG_ROOT) begin
        root_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_PRIO) begin
        prio_r <= cfg_data[BYTE_W-1:0];
      end
    end
    shift_r    <= shift_nxt;
    bit_r      <= bit_nxt;
    next_r     <= next_nxt;
    rd_oor_r   <= rd_oor;
    sym_data_r <= sym_data_nxt;
    sym_eod_r  <= sym_eod_nxt;
    rep_r      <= rep_nxt;
  end

endmodule
`default_nettype wire
